FILE: rtl/core/sfb_pkg.sv
// Shared constants, codes and types of the stereo FIR binaural convolver.
// Used by every module under rtl/core except sfb_ram; depends on nothing else.
`timescale 1ns / 1ps

package sfb_pkg;

   // Coefficient store depth and derived widths.
   localparam int TAP_DEPTH   = 256;
   localparam int TAP_AW      = $clog2(TAP_DEPTH);
   localparam int TAP_CNT_W   = 9;
   localparam int SUM_DEPTH   = TAP_DEPTH - 1;
   localparam int SUM_AW      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

   // Field widths.
   localparam int SAMPLE_W    = 16;
   localparam int TAP_INDEX_W = 8;
   localparam int GAIN_W      = 16;
   localparam int DIST_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Datapath widths.
   localparam int SUM_W       = 40;
   localparam int MUL_W       = SAMPLE_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DSQ_W       = 2 * DIST_W;
   localparam int SCALE_SHIFT = 11;
   localparam int HALF_SHIFT  = SCALE_SHIFT - 1;
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = 3;
   localparam int MAG_W       = CHUNK_W * CHUNKS;
   localparam int NUM_W       = 56;
   localparam int DEN_W       = DSQ_W + SCALE_SHIFT;
   localparam int QUOT_W      = 16;
   localparam int DIV_HI_W    = NUM_W - QUOT_W;
   localparam int CMP_W       = (DIV_HI_W > DEN_W) ? DIV_HI_W : DEN_W;
   localparam int DIV_CNT_W   = $clog2(QUOT_W);

   // Command codes.
   localparam logic CMD_AUDIO = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE  = 2'd2;

   // Register reset values; unity distance is 1.0 in Q8.8.
   localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = '0;
   localparam logic [GAIN_W-1:0]    GAIN_RST      = 16'd4096;
   localparam logic [DIST_W-1:0]    DIST_UNITY    = 16'd256;

   // Output saturation limits.
   localparam logic [SAMPLE_W-1:0] OUT_MAX     = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] OUT_MIN     = 16'h8000;
   localparam logic [QUOT_W-1:0]   POS_LIMIT   = 16'd32767;
   localparam logic [QUOT_W-1:0]   NEG_LIMIT   = 16'd32768;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } sfb_div_req_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } sfb_div_res_type;

endpackage

FILE: rtl/core/sfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package is needed.
`timescale 1ns / 1ps

module sfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sfb_mul.sv
// Shared signed multiplier with a registered product.
// Depends on sfb_pkg for the operand and product widths.
`timescale 1ns / 1ps

module sfb_mul (
   input  logic                              clock,
   input  logic signed [sfb_pkg::MUL_W-1:0]  op_a,
   input  logic signed [sfb_pkg::MUL_W-1:0]  op_b,
   output logic signed [sfb_pkg::PROD_W-1:0] prod
);

   import sfb_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/sfb_div.sv
// Restoring divider, one quotient bit per cycle, with early overflow detect.
// Depends on sfb_pkg for widths and the request and result types.
`timescale 1ns / 1ps

module sfb_div (
   input  logic                     clock,
   input  logic                     reset,
   input  sfb_pkg::sfb_div_req_type div_req,
   output sfb_pkg::sfb_div_res_type div_res
);

   import sfb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0]    num_ff, num_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;

   logic [DIV_HI_W-1:0]  num_hi;
   logic                 too_big;
   logic [DEN_W:0]       trial;
   logic                 fits;
   logic [DEN_W:0]       trial_sub;

   assign num_hi    = div_req.num[NUM_W-1:QUOT_W];
   // The quotient cannot fit when the upper dividend bits already reach the divisor.
   assign too_big   = CMP_W'(num_hi) >= CMP_W'(div_req.den);
   assign trial     = {rem_ff, num_ff[QUOT_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         den_in  = div_req.den;
         num_in  = div_req.num[QUOT_W-1:0];
         rem_in  = DEN_W'(num_hi);
         quot_in = '0;
         cnt_in  = DIV_CNT_W'(QUOT_W - 1);
         ovf_in  = too_big;
         if (too_big) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         num_in  = {num_ff[QUOT_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign div_res.done = done_ff;
   assign div_res.ovf  = ovf_ff;
   assign div_res.quot = quot_ff;

endmodule

FILE: rtl/core/stereo_fir_binaural_convolver.sv
// Stereo FIR binaural convolver: each audio transfer is a mono Q1.15 sample that is filtered
// through a left and a right impulse response in transposed form, scaled by the Q4.12 gain
// and by 1/d^2 for distances above 1.0, rounded and saturated into one stereo result.
// One shared 17x17 multiplier does two products per tap. The scaling tail is paced by
// the bit-serial divider (16 steps per channel), and a channel whose quotient overflows
// skips those steps. A tap-load transfer gives no result. The request side is stalled
// while an audio item is being worked on, and also while its finished result waits for
// the output register to free up.
`timescale 1ns / 1ps

module stereo_fir_binaural_convolver (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_command,
   input  logic signed [sfb_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic        [sfb_pkg::TAP_INDEX_W-1:0] req_tap_index,
   input  logic signed [sfb_pkg::SAMPLE_W-1:0]    req_tap_left,
   input  logic signed [sfb_pkg::SAMPLE_W-1:0]    req_tap_right,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sfb_pkg::SAMPLE_W-1:0]    rsp_out_left,
   output logic signed [sfb_pkg::SAMPLE_W-1:0]    rsp_out_right,
   output logic                                   rsp_clipped,
   input  logic                                   csr_wr_en,
   input  logic        [sfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [sfb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sfb_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIR   = 4'd1;
   localparam logic [3:0] ST_DSQ   = 4'd2;
   localparam logic [3:0] ST_DSQW  = 4'd3;
   localparam logic [3:0] ST_MAG   = 4'd4;
   localparam logic [3:0] ST_PP    = 4'd5;
   localparam logic [3:0] ST_DIVGO = 4'd6;
   localparam logic [3:0] ST_DIVW  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   localparam int COEF_W = 2 * SAMPLE_W;
   localparam int PAIR_W = 2 * SUM_W;

   // Control state.
   logic [3:0]           state_ff, state_in;
   logic [TAP_CNT_W-1:0] iss_ff, iss_in;
   logic                 gap_ff, gap_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 mr_ff, mr_in;
   logic                 ar_ff, ar_in;
   logic [TAP_AW-1:0]    hw_ff, hw_in;
   logic [TAP_DEPTH-1:0] cvalid_ff, cvalid_in;
   logic [TAP_CNT_W-1:0] tap_count_ff, tap_count_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [TAP_CNT_W-1:0]       len_ff, len_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [TAP_AW-1:0]          s1_idx_ff, s1_idx_in;
   logic [TAP_AW-1:0]          idx_h_ff, idx_h_in;
   logic signed [SAMPLE_W-1:0] hr_ff, hr_in;
   logic [SUM_W-1:0]           sl_ff, sl_in;
   logic [SUM_W-1:0]           sr_ff, sr_in;
   logic [SUM_W-1:0]           resl_ff, resl_in;
   logic [SUM_W-1:0]           acc_l_ff, acc_l_in;
   logic [SUM_W-1:0]           acc_r_ff, acc_r_in;
   logic [DSQ_W-1:0]           dsq_ff, dsq_in;
   logic                       chan_ff, chan_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [NUM_W-1:0]           macc_ff, macc_in;
   logic [SAMPLE_W-1:0]        yl_ff, yl_in;
   logic [SAMPLE_W-1:0]        yr_ff, yr_in;
   logic                       clip_ff, clip_in;
   logic [SAMPLE_W-1:0]        rsp_left_ff, rsp_left_in;
   logic [SAMPLE_W-1:0]        rsp_right_ff, rsp_right_in;
   logic                       rsp_clip_ff, rsp_clip_in;

   // Combinational signals.
   logic                     accept;
   logic                     do_load;
   logic                     issue_now;
   logic                     out_free;
   logic [TAP_CNT_W-1:0]     len_calc;
   logic [DIST_W-1:0]        dist_eff;
   logic [COEF_W-1:0]        coef_q;
   logic [PAIR_W-1:0]        sum_q;
   logic signed [SAMPLE_W-1:0] hl_m, hr_m;
   logic                     sum_hit;
   logic [SUM_W-1:0]         sl_m, sr_m;
   logic signed [PROD_W-1:0] prod;
   logic [SUM_W-1:0]         prod_ext;
   logic [SUM_W-1:0]         vr;
   logic [SUM_W-1:0]         acc_sel;
   logic [SUM_W-1:0]         acc_mag;
   logic [CHUNK_W-1:0]       chunk;
   logic [DSQ_W-1:0]         pp;
   logic [NUM_W-1:0]         pp_add;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     sum_wr_en;
   logic                     sum_rd_en;
   logic [SAMPLE_W-1:0]      sat_y;
   logic                     sat_clip;
   sfb_div_req_type          div_req;
   sfb_div_res_type          div_res;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign do_load   = accept && (req_command == CMD_LOAD) &&
                      ({1'b0, req_tap_index} < (TAP_INDEX_W + 1)'(TAP_DEPTH));
   assign issue_now = (state_ff == ST_FIR) && (iss_ff < len_ff) && !gap_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign len_calc  = (tap_count_ff > TAP_CNT_W'(TAP_DEPTH)) ? TAP_CNT_W'(TAP_DEPTH)
                                                             : tap_count_ff;
   assign dist_eff  = (dist_ff < DIST_UNITY) ? DIST_UNITY : dist_ff;

   sfb_ram #(.WIDTH(COEF_W), .DEPTH(TAP_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (req_tap_index[TAP_AW-1:0]),
      .wr_data ({req_tap_left, req_tap_right}),
      .rd_en   (issue_now),
      .rd_addr (iss_ff[TAP_AW-1:0]),
      .rd_data (coef_q)
   );

   // Entry k of the sum store is read while tap k is worked on, and entry k-1 is
   // written once tap k has passed through its left and right products, after that read,
   // so a read always sees the previous sample's value.
   assign sum_wr_en = ar_ff && (idx_h_ff != '0);
   assign sum_rd_en = issue_now && (iss_ff < TAP_CNT_W'(SUM_DEPTH));

   sfb_ram #(.WIDTH(PAIR_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (SUM_AW'(idx_h_ff - 1'b1)),
      .wr_data ({resl_ff, vr}),
      .rd_en   (sum_rd_en),
      .rd_addr (SUM_AW'(iss_ff)),
      .rd_data (sum_q)
   );

   sfb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign div_req.start = (state_ff == ST_DIVGO);
   assign div_req.num   = macc_ff;
   assign div_req.den   = {dsq_ff, SCALE_SHIFT'(0)};

   sfb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   // Taps that were never loaded read as zero, as do sums above the last written one.
   assign hl_m     = cvalid_ff[s1_idx_ff] ? coef_q[COEF_W-1:SAMPLE_W] : '0;
   assign hr_m     = cvalid_ff[s1_idx_ff] ? coef_q[SAMPLE_W-1:0] : '0;
   assign sum_hit  = s1_idx_ff < hw_ff;
   assign sl_m     = sum_hit ? sum_q[PAIR_W-1:SUM_W] : '0;
   assign sr_m     = sum_hit ? sum_q[SUM_W-1:0] : '0;
   assign prod_ext = {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
   assign vr       = prod_ext + sr_ff;
   assign acc_sel  = chan_ff ? acc_r_ff : acc_l_ff;
   assign acc_mag  = acc_sel[SUM_W-1] ? (SUM_W'(0) - acc_sel) : acc_sel;
   assign pp       = prod[DSQ_W-1:0];

   always_comb begin
      case (cnt_ff)
         2'd0:    chunk = mag_ff[CHUNK_W-1:0];
         2'd1:    chunk = mag_ff[2*CHUNK_W-1:CHUNK_W];
         default: chunk = mag_ff[3*CHUNK_W-1:2*CHUNK_W];
      endcase
   end

   always_comb begin
      case (cnt_ff)
         2'd1:    pp_add = NUM_W'(pp);
         2'd2:    pp_add = NUM_W'({pp, CHUNK_W'(0)});
         2'd3:    pp_add = NUM_W'({pp, (2 * CHUNK_W)'(0)});
         default: pp_add = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_FIR: begin
            mul_a = MUL_W'(x_ff);
            mul_b = s1_vld_ff ? MUL_W'(hl_m) : MUL_W'(hr_ff);
         end
         ST_DSQ: begin
            mul_a = {1'b0, dist_eff};
            mul_b = {1'b0, dist_eff};
         end
         ST_PP: begin
            mul_a = {1'b0, chunk};
            mul_b = {1'b0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Round-to-nearest already sits in the dividend; only the sign and saturation are left here.
   always_comb begin
      sat_clip = 1'b0;
      if (neg_ff) begin
         if (div_res.ovf || (div_res.quot > NEG_LIMIT)) begin
            sat_y    = OUT_MIN;
            sat_clip = 1'b1;
         end else begin
            sat_y = SAMPLE_W'(0) - div_res.quot;
         end
      end else begin
         if (div_res.ovf || (div_res.quot > POS_LIMIT)) begin
            sat_y    = OUT_MAX;
            sat_clip = 1'b1;
         end else begin
            sat_y = div_res.quot;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff + TAP_CNT_W'(issue_now);
      gap_in       = issue_now;
      s1_vld_in    = issue_now;
      s1_idx_in    = iss_ff[TAP_AW-1:0];
      mr_in        = s1_vld_ff;
      ar_in        = mr_ff;
      hw_in        = hw_ff;
      cvalid_in    = cvalid_ff;
      tap_count_in = tap_count_ff;
      gain_in      = gain_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff;
      len_in       = len_ff;
      x_in         = x_ff;
      idx_h_in     = idx_h_ff;
      hr_in        = hr_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      resl_in      = resl_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      dsq_in       = dsq_ff;
      chan_in      = chan_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      macc_in      = macc_ff;
      yl_in        = yl_ff;
      yr_in        = yr_ff;
      clip_in      = clip_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_clip_in  = rsp_clip_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_TAP_COUNT: tap_count_in = csr_wdata[TAP_CNT_W-1:0];
            CSR_GAIN:      gain_in      = csr_wdata[GAIN_W-1:0];
            CSR_DISTANCE:  dist_in      = csr_wdata[DIST_W-1:0];
            default:       tap_count_in = tap_count_ff;
         endcase
      end

      if (do_load) begin
         cvalid_in[req_tap_index[TAP_AW-1:0]] = 1'b1;
      end

      // Tap pipeline: left product, then right product with the left sum, then the pair.
      if (s1_vld_ff) begin
         hr_in    = hr_m;
         sl_in    = sl_m;
         sr_in    = sr_m;
         idx_h_in = s1_idx_ff;
      end
      if (mr_ff) begin
         resl_in = prod_ext + sl_ff;
      end
      if (ar_ff && (idx_h_ff == '0)) begin
         acc_l_in = resl_ff;
         acc_r_in = vr;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_AUDIO)) begin
               clip_in  = 1'b0;
               len_in   = len_calc;
               x_in     = req_sample_in;
               acc_l_in = '0;
               acc_r_in = '0;
               iss_in   = '0;
               gap_in   = 1'b0;
               if (len_calc == '0) begin
                  hw_in    = '0;
                  state_in = ST_DSQ;
               end else begin
                  state_in = ST_FIR;
               end
            end
         end
         ST_FIR: begin
            if (ar_ff && ({1'b0, idx_h_ff} == (len_ff - 1'b1))) begin
               hw_in    = TAP_AW'(len_ff - 1'b1);
               state_in = ST_DSQ;
            end
         end
         ST_DSQ: begin
            state_in = ST_DSQW;
         end
         ST_DSQW: begin
            dsq_in   = pp;
            chan_in  = 1'b0;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = acc_sel[SUM_W-1];
            mag_in   = MAG_W'(acc_mag);
            macc_in  = NUM_W'({dsq_ff, HALF_SHIFT'(0)});
            cnt_in   = '0;
            state_in = ST_PP;
         end
         ST_PP: begin
            cnt_in  = cnt_ff + 1'b1;
            macc_in = macc_ff + pp_add;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_res.done) begin
               clip_in = clip_ff | sat_clip;
               if (!chan_ff) begin
                  yl_in    = sat_y;
                  chan_in  = 1'b1;
                  state_in = ST_MAG;
               end else begin
                  yr_in    = sat_y;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = yl_ff;
               rsp_right_in = yr_ff;
               rsp_clip_in  = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         gap_ff       <= 1'b0;
         s1_vld_ff    <= 1'b0;
         mr_ff        <= 1'b0;
         ar_ff        <= 1'b0;
         hw_ff        <= '0;
         cvalid_ff    <= '0;
         tap_count_ff <= TAP_COUNT_RST;
         gain_ff      <= GAIN_RST;
         dist_ff      <= DIST_UNITY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         gap_ff       <= gap_in;
         s1_vld_ff    <= s1_vld_in;
         mr_ff        <= mr_in;
         ar_ff        <= ar_in;
         hw_ff        <= hw_in;
         cvalid_ff    <= cvalid_in;
         tap_count_ff <= tap_count_in;
         gain_ff      <= gain_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      x_ff         <= x_in;
      s1_idx_ff    <= s1_idx_in;
      idx_h_ff     <= idx_h_in;
      hr_ff        <= hr_in;
      sl_ff        <= sl_in;
      sr_ff        <= sr_in;
      resl_ff      <= resl_in;
      acc_l_ff     <= acc_l_in;
      acc_r_ff     <= acc_r_in;
      dsq_ff       <= dsq_in;
      chan_ff      <= chan_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      cnt_ff       <= cnt_in;
      macc_ff      <= macc_in;
      yl_ff        <= yl_in;
      yr_ff        <= yr_in;
      clip_ff      <= clip_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule
